>>> rtl/open_addressing_hash_table_defines.svh
// Assertion macros for the open-addressing hash table.
// Depends on nothing; included by modules that carry assertions.
`ifndef OPEN_ADDRESSING_HASH_TABLE_DEFINES_SVH
`define OPEN_ADDRESSING_HASH_TABLE_DEFINES_SVH
`ifndef ASSERT_OFF
`define OAHT_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define OAHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OAHT_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define OAHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/oaht_pkg.sv
// Shared types, constants and the CRC step function for the hash table.
// Depends on nothing.
package oaht_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int MAX_PROBES    = 16;
    localparam int PROBE_W       = $clog2(MAX_PROBES + 1);
    localparam int KEY_W         = 64;
    localparam int CNT_W         = 9;
    localparam int CRC_BITS      = 8;
    localparam int CRC_STEPS     = KEY_W / CRC_BITS;
    localparam int CRC_CNT_W     = $clog2(CRC_STEPS);

    localparam logic [KEY_W-1:0] CRC_POLY = 64'hC96C5795D7870F42;
    localparam logic [CNT_W-1:0] LIMIT_RESET = 9'd128;

    localparam logic OP_FIND   = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam logic [2:0] ST_FOUND     = 3'd0;
    localparam logic [2:0] ST_INSERTED  = 3'd1;
    localparam logic [2:0] ST_REPLACED  = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic             op;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [KEY_W-1:0] value_out;
        logic [7:0]       slot;
        logic [CNT_W-1:0] entries_used;
    } rsp_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_CHECK = 5'b00100,
        S_CRC   = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    function automatic logic [KEY_W-1:0] crc_step(input logic [KEY_W-1:0] crc_in);
        logic [KEY_W-1:0] c;
        c = crc_in;
        for (int i = 0; i < CRC_BITS; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/open_addressing_hash_table.sv
// Open-addressing hash table top level; uses oaht_pkg, oaht_ram and the defines header.
// A request is accepted in idle, then the RAMs are read, the slot is checked and the result
// is presented; each rehash runs the shared 8-bit-per-cycle CRC unit over the previous hash,
// then one RAM read and one compare. A new request is accepted only after the result is taken.
// Reset: asynchronous active low; clears occupied bits, entry count, limit (to 128).
`include "open_addressing_hash_table_defines.svh"

module open_addressing_hash_table (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  oaht_pkg::req_t                       in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output oaht_pkg::rsp_t                       out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [oaht_pkg::CNT_W-1:0]           cfg_data
);

    oaht_pkg::state_t                       state_reg, state_next;
    logic [oaht_pkg::TABLE_ENTRIES-1:0]     occupied_reg, occupied_next;
    logic [oaht_pkg::CNT_W-1:0]             count_reg, count_next;
    logic [oaht_pkg::CNT_W-1:0]             limit_reg;
    logic [oaht_pkg::CRC_CNT_W-1:0]         crc_cnt_reg, crc_cnt_next;
    logic [oaht_pkg::PROBE_W-1:0]           probes_reg, probes_next;
    logic                                   op_reg, op_next;
    logic [oaht_pkg::KEY_W-1:0]             key_reg, key_next;
    logic [oaht_pkg::KEY_W-1:0]             value_reg, value_next;
    logic [oaht_pkg::KEY_W-1:0]             h_reg, h_next;
    logic [oaht_pkg::KEY_W-1:0]             crc_reg, crc_next;
    logic [oaht_pkg::IDX_W-1:0]             idx_reg, idx_next;
    oaht_pkg::rsp_t                         rsp_reg, rsp_next;

    logic [oaht_pkg::KEY_W-1:0]             key_rd;
    logic [oaht_pkg::KEY_W-1:0]             val_rd;
    logic [oaht_pkg::KEY_W-1:0]             crc_stepped;
    logic                                   key_we;
    logic                                   val_we;

    assign in_ready  = (state_reg == oaht_pkg::S_IDLE);
    assign out_valid = (state_reg == oaht_pkg::S_RESP);
    assign out_data  = rsp_reg;
    assign cfg_ready = 1'b1;

    assign crc_stepped = oaht_pkg::crc_step(crc_reg);

    oaht_ram #(.WIDTH(oaht_pkg::KEY_W), .DEPTH(oaht_pkg::TABLE_ENTRIES)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (idx_reg),
        .wdata (key_reg),
        .raddr (idx_reg),
        .rdata (key_rd)
    );

    oaht_ram #(.WIDTH(oaht_pkg::KEY_W), .DEPTH(oaht_pkg::TABLE_ENTRIES)) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (idx_reg),
        .wdata (value_reg),
        .raddr (idx_reg),
        .rdata (val_rd)
    );

    always_comb
    begin
        state_next    = state_reg;
        occupied_next = occupied_reg;
        count_next    = count_reg;
        crc_cnt_next  = crc_cnt_reg;
        probes_next   = probes_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        value_next    = value_reg;
        h_next        = h_reg;
        crc_next      = crc_reg;
        idx_next      = idx_reg;
        rsp_next      = rsp_reg;
        key_we        = 1'b0;
        val_we        = 1'b0;

        case (state_reg)
            oaht_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = in_data.op;
                    key_next    = in_data.key;
                    value_next  = in_data.value;
                    h_next      = in_data.key;
                    idx_next    = in_data.key[oaht_pkg::IDX_W-1:0];
                    probes_next = oaht_pkg::PROBE_W'(1);
                    state_next  = oaht_pkg::S_READ;
                end
            end
            oaht_pkg::S_READ:
            begin
                state_next = oaht_pkg::S_CHECK;
            end
            oaht_pkg::S_CHECK:
            begin
                rsp_next.value_out = '0;
                rsp_next.slot      = 8'(idx_reg);
                state_next         = oaht_pkg::S_RESP;
                if (!occupied_reg[idx_reg])
                begin
                    if (op_reg == oaht_pkg::OP_INSERT)
                    begin
                        if (count_reg >= limit_reg)
                        begin
                            rsp_next.status = oaht_pkg::ST_FULL;
                        end
                        else
                        begin
                            key_we                 = 1'b1;
                            val_we                 = 1'b1;
                            occupied_next[idx_reg] = 1'b1;
                            count_next             = count_reg + 1'b1;
                            rsp_next.status        = oaht_pkg::ST_INSERTED;
                        end
                    end
                    else
                    begin
                        rsp_next.status = oaht_pkg::ST_NOT_FOUND;
                    end
                end
                else if (key_rd == key_reg)
                begin
                    if (op_reg == oaht_pkg::OP_INSERT)
                    begin
                        val_we          = 1'b1;
                        rsp_next.status = oaht_pkg::ST_REPLACED;
                    end
                    else
                    begin
                        rsp_next.status    = oaht_pkg::ST_FOUND;
                        rsp_next.value_out = val_rd;
                    end
                end
                else if (probes_reg == oaht_pkg::PROBE_W'(oaht_pkg::MAX_PROBES))
                begin
                    rsp_next.status = oaht_pkg::ST_FULL;
                end
                else
                begin
                    crc_next     = ~h_reg;
                    crc_cnt_next = '0;
                    state_next   = oaht_pkg::S_CRC;
                end
                rsp_next.entries_used = count_next;
            end
            oaht_pkg::S_CRC:
            begin
                crc_next     = crc_stepped;
                crc_cnt_next = crc_cnt_reg + 1'b1;
                if (crc_cnt_reg == oaht_pkg::CRC_CNT_W'(oaht_pkg::CRC_STEPS - 1))
                begin
                    h_next      = ~crc_stepped;
                    idx_next    = ~crc_stepped[oaht_pkg::IDX_W-1:0];
                    probes_next = probes_reg + 1'b1;
                    state_next  = oaht_pkg::S_READ;
                end
            end
            oaht_pkg::S_RESP:
            begin
                if (out_ready)
                begin
                    state_next = oaht_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = oaht_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= oaht_pkg::S_IDLE;
            occupied_reg <= '0;
            count_reg    <= '0;
            limit_reg    <= oaht_pkg::LIMIT_RESET;
            crc_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            occupied_reg <= occupied_next;
            count_reg    <= count_next;
            crc_cnt_reg  <= crc_cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        probes_reg <= probes_next;
        op_reg     <= op_next;
        key_reg    <= key_next;
        value_reg  <= value_next;
        h_reg      <= h_next;
        crc_reg    <= crc_next;
        idx_reg    <= idx_next;
        rsp_reg    <= rsp_next;
    end

    `OAHT_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= oaht_pkg::CNT_W'(oaht_pkg::TABLE_ENTRIES), "entry count above table size")
    `OAHT_ASSERT_NEXT(a_count_hold, clk, rst_n, state_reg != oaht_pkg::S_CHECK, $stable(count_reg), "entry count changed outside check")
    `OAHT_ASSERT_NEXT(a_count_count, clk, rst_n, 1'b1, $countones(occupied_reg) == count_reg, "entry count disagrees with occupied bits")
    `OAHT_ASSERT_ALWAYS(a_probe_bound, clk, rst_n, !(state_reg == oaht_pkg::S_CHECK) || (probes_reg >= oaht_pkg::PROBE_W'(1) && probes_reg <= oaht_pkg::PROBE_W'(oaht_pkg::MAX_PROBES)), "probe count out of range")

endmodule

>>> rtl/oaht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module oaht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
